[hw/rtl/sss_pkg.sv]
// Shared types and constants for the scan stroke segmenter.
// Holds the field widths, the register indexes and the quarter-wave cosine
// table builder. It depends on nothing else.
`default_nettype none

package sss_pkg;

    localparam int IDX_W       = 10;
    localparam int RANGE_W     = 16;
    localparam int ANG_W       = 12;
    localparam int CFG_W       = 16;
    localparam int POS_W       = 17;
    localparam int MAG_W       = 15;
    localparam int PROD_W      = RANGE_W + MAG_W;
    localparam int DIFF_W      = POS_W + 1;
    localparam int ABS_W       = POS_W;
    localparam int SQ_W        = 2 * ABS_W;
    localparam int CSQ_W       = 2 * CFG_W;
    localparam int DSUM_W      = SQ_W + 1;

    localparam int ANGLE_STEPS = 4096;
    localparam int HALF        = ANGLE_STEPS / 2;
    localparam int QUARTER     = ANGLE_STEPS / 4;
    localparam int K_W         = $clog2(QUARTER + 1);

    localparam int MUL_STEPS   = RANGE_W;
    localparam int SQR_STEPS   = ABS_W;
    localparam int CNT_W       = $clog2(SQR_STEPS + 1);

    // Register indexes of the configuration port.
    localparam logic CFG_HORIZON = 1'b0;
    localparam logic CFG_CONNECT = 1'b1;

    localparam logic [63:0] ONE_Q60 = 64'h1000_0000_0000_0000;
    localparam logic [63:0] PI_Q60  = 64'h3243_F6A8_885A_308D;

    typedef logic [MAG_W-1:0] t_mag_tab [0:QUARTER];

    // Folded angle: table address and sign of the cosine.
    typedef struct packed {
        logic           neg;
        logic [K_W-1:0] k;
    } t_fold;

    // Magnitudes round(32767*cos(2*pi*k/ANGLE_STEPS)) for the first quarter
    // turn, from a Q60 Taylor series with exact values at the special angles.
    // Evaluated once at elaboration.
    function automatic t_mag_tab f_mag_tab();
        t_mag_tab     tab;
        logic [63:0]  m;
        logic [63:0]  x;
        logic [63:0]  x2;
        logic [63:0]  term;
        logic [63:0]  sum;
        logic [63:0]  a;
        logic [63:0]  c;
        logic [63:0]  mag;
        logic [127:0] p;
        int           k;
        int           n;
        for (k = 0; k <= QUARTER; k++) begin
            m = 64'(2 * k);
            if (m == 64'd0) begin
                mag = 64'd32767;
            end else if (2 * m == 64'(ANGLE_STEPS)) begin
                mag = 64'd0;
            end else if (3 * m == 64'(ANGLE_STEPS)) begin
                mag = 64'd16384;
            end else begin
                x = (PI_Q60 / 64'(ANGLE_STEPS)) * m
                    + ((PI_Q60 % 64'(ANGLE_STEPS)) * m) / 64'(ANGLE_STEPS);
                p = {64'd0, x} * {64'd0, x};
                x2 = p[123:60];
                term = ONE_Q60;
                sum = ONE_Q60;
                for (n = 1; n <= 15; n++) begin
                    p = {64'd0, term} * {64'd0, x2};
                    term = p[123:60] / 64'((2 * n - 1) * (2 * n));
                    if ((n % 2) == 1) begin
                        sum = sum - term;
                    end else begin
                        sum = sum + term;
                    end
                end
                if (sum > (ONE_Q60 << 1)) begin
                    sum = 64'd0;
                end else if (sum > ONE_Q60) begin
                    sum = ONE_Q60;
                end
                a = 64'd32767 * (sum >> 30);
                c = 64'd32767 * (sum & 64'h3FFF_FFFF) + (64'd1 << 59);
                mag = (a + (c >> 30)) >> 30;
            end
            tab[k] = MAG_W'(mag);
        end
        return tab;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/scan_stroke_segmenter.sv]
// Scan stroke segmenter: converts one laser ray per beat into a cartesian
// point and splits the scan into strokes. Depends on sss_pkg.
// An unusable ray goes straight to the output, behind the held point when a scan end
// flushes that first; a usable ray passes the table reads, the bit-serial multipliers
// (16 steps) and, when a previous point is held, the squarers (17 steps) before any
// beat. One ray is in flight at a time: no new ray is taken until its beats are out.
// Reset is synchronous and active low: it drops the held point and restores the
// register defaults.
`default_nettype none

module scan_stroke_segmenter
    import sss_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,

    input  wire logic                    i_cfg_we,
    input  wire logic                    i_cfg_index,
    input  wire logic [CFG_W-1:0]        i_cfg_data,

    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic [IDX_W-1:0]        i_ray_index,
    input  wire logic [RANGE_W-1:0]      i_range_mm,
    input  wire logic [ANG_W-1:0]        i_angle,
    input  wire logic                    i_ray_ok,
    input  wire logic                    i_scan_end,

    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic [IDX_W-1:0]             o_out_index,
    output logic                         o_usable,
    output logic signed [POS_W-1:0]      o_pos_x,
    output logic signed [POS_W-1:0]      o_pos_y,
    output logic                         o_begins_stroke,
    output logic                         o_ends_stroke,
    output logic                         o_run_last
);

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_ROM  = 10'b00_0000_0010,
        S_ROM2 = 10'b00_0000_0100,
        S_LOAD = 10'b00_0000_1000,
        S_MUL  = 10'b00_0001_0000,
        S_PROJ = 10'b00_0010_0000,
        S_DIFF = 10'b00_0100_0000,
        S_SQR  = 10'b00_1000_0000,
        S_CMP  = 10'b01_0000_0000,
        S_EMIT = 10'b10_0000_0000
    } t_state;

    localparam t_mag_tab COS_TAB = f_mag_tab();

    // Reduce an angle to the first quarter turn and remember the sign.
    function automatic t_fold f_fold(input logic [ANG_W-1:0] a);
        logic [ANG_W:0] ap;
        t_fold          r;
        if ({1'b0, a} > (ANG_W+1)'(HALF)) begin
            ap = (ANG_W+1)'(ANGLE_STEPS) - {1'b0, a};
        end else begin
            ap = {1'b0, a};
        end
        if (ap > (ANG_W+1)'(QUARTER)) begin
            r.neg = 1'b1;
            r.k   = K_W'((ANG_W+1)'(HALF) - ap);
        end else begin
            r.neg = 1'b0;
            r.k   = K_W'(ap);
        end
        return r;
    endfunction

    // Control state
    t_state               r_state, n_state;
    logic [RANGE_W-1:0]   r_horizon;
    logic [CFG_W-1:0]     r_connect;
    logic                 r_held_vld;
    logic                 r_emit_held;
    logic                 r_emit_cur;
    logic                 r_held_end;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_o_valid;

    // Current ray
    logic [IDX_W-1:0]     r_cur_idx;
    logic [RANGE_W-1:0]   r_cur_range;
    logic [ANG_W-1:0]     r_cur_ang;
    logic                 r_cur_use;
    logic                 r_cur_last;
    logic                 r_cur_beg;
    logic signed [POS_W-1:0] r_x;
    logic signed [POS_W-1:0] r_y;

    // Held point
    logic [IDX_W-1:0]     r_held_idx;
    logic signed [POS_W-1:0] r_held_x;
    logic signed [POS_W-1:0] r_held_y;
    logic                 r_held_beg;

    // Table read and projection multipliers
    logic [MAG_W-1:0]     r_rom_q;
    logic                 r_neg_x;
    logic                 r_neg_y;
    logic [RANGE_W-1:0]   r_mr;
    logic [PROD_W-1:0]    r_mx;
    logic [PROD_W-1:0]    r_my;
    logic [PROD_W-1:0]    r_px;
    logic [PROD_W-1:0]    r_py;

    // Squarers
    logic [ABS_W-1:0]     r_qmx;
    logic [ABS_W-1:0]     r_qmy;
    logic [ABS_W-1:0]     r_qmc;
    logic [SQ_W-1:0]      r_qax;
    logic [SQ_W-1:0]      r_qay;
    logic [CSQ_W-1:0]     r_qac;
    logic [SQ_W-1:0]      r_sqx;
    logic [SQ_W-1:0]      r_sqy;
    logic [CSQ_W-1:0]     r_sqc;

    // Output register payload
    logic [IDX_W-1:0]     r_o_idx;
    logic                 r_o_use;
    logic signed [POS_W-1:0] r_o_x;
    logic signed [POS_W-1:0] r_o_y;
    logic                 r_o_beg;
    logic                 r_o_end;
    logic                 r_o_last;

    logic                 in_fire;
    logic                 in_usable;
    logic                 slot_free;
    logic                 emit_fire;
    t_fold                fold_x;
    t_fold                fold_y;
    logic [K_W-1:0]       rom_addr;
    logic signed [PROD_W+1:0] sx;
    logic signed [PROD_W+1:0] sy;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic [ABS_W-1:0]     adx;
    logic [ABS_W-1:0]     ady;
    logic [DSUM_W-1:0]    d2;
    logic                 new_beg;

    assign in_fire   = i_valid && !o_stall;
    assign in_usable = i_ray_ok && (i_range_mm <= r_horizon);
    assign slot_free = !r_o_valid || !i_stall;
    assign emit_fire = (r_state == S_EMIT) && slot_free && (r_emit_held || r_emit_cur);

    assign fold_x   = f_fold(r_cur_ang);
    assign fold_y   = f_fold(r_cur_ang - ANG_W'(QUARTER));
    assign rom_addr = (r_state == S_ROM) ? fold_x.k : fold_y.k;

    // Round to nearest with the sign applied before the shift (floor).
    assign sx = (r_neg_x ? -$signed({2'b00, r_px}) : $signed({2'b00, r_px}))
                + (PROD_W+2)'(16384);
    assign sy = (r_neg_y ? -$signed({2'b00, r_py}) : $signed({2'b00, r_py}))
                + (PROD_W+2)'(16384);

    assign dx  = DIFF_W'(r_x) - DIFF_W'(r_held_x);
    assign dy  = DIFF_W'(r_y) - DIFF_W'(r_held_y);
    assign adx = dx[DIFF_W-1] ? ABS_W'(-dx) : ABS_W'(dx);
    assign ady = dy[DIFF_W-1] ? ABS_W'(-dy) : ABS_W'(dy);

    assign d2      = {1'b0, r_sqx} + {1'b0, r_sqy};
    assign new_beg = !(DSUM_W'(r_sqc) > d2);

    always_ff @(posedge i_clk) begin
        r_rom_q <= COS_TAB[rom_addr];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = in_usable ? S_ROM : S_EMIT;
                end
            end
            S_ROM:  n_state = S_ROM2;
            S_ROM2: n_state = S_LOAD;
            S_LOAD: n_state = S_MUL;
            S_MUL: begin
                if (r_cnt == CNT_W'(MUL_STEPS - 1)) begin
                    n_state = S_PROJ;
                end
            end
            S_PROJ: n_state = S_DIFF;
            S_DIFF: n_state = r_held_vld ? S_SQR : S_EMIT;
            S_SQR: begin
                if (r_cnt == CNT_W'(SQR_STEPS - 1)) begin
                    n_state = S_CMP;
                end
            end
            S_CMP:  n_state = S_EMIT;
            S_EMIT: begin
                if (!r_emit_held && !r_emit_cur) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_horizon   <= RANGE_W'(65535);
            r_connect   <= CFG_W'(100);
            r_held_vld  <= 1'b0;
            r_emit_held <= 1'b0;
            r_emit_cur  <= 1'b0;
            r_held_end  <= 1'b0;
            r_cnt       <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_HORIZON: r_horizon <= i_cfg_data;
                    CFG_CONNECT: r_connect <= i_cfg_data;
                    default:     r_connect <= r_connect;
                endcase
            end

            if (r_state == S_LOAD || r_state == S_DIFF) begin
                r_cnt <= '0;
            end else begin
                r_cnt <= r_cnt + CNT_W'(1);
            end

            priority case (1'b1)
                (r_state == S_IDLE) && in_fire && !in_usable: begin
                    // An unusable ray passes through; a scan end flushes the held point first.
                    r_emit_held <= i_scan_end && r_held_vld;
                    r_held_end  <= 1'b1;
                    r_emit_cur  <= 1'b1;
                end
                (r_state == S_DIFF) && !r_held_vld: begin
                    r_emit_held <= 1'b0;
                    r_emit_cur  <= r_cur_last;
                end
                (r_state == S_CMP): begin
                    r_emit_held <= 1'b1;
                    r_held_end  <= new_beg;
                    r_emit_cur  <= r_cur_last;
                end
                emit_fire: begin
                    if (r_emit_held) begin
                        r_emit_held <= 1'b0;
                    end else begin
                        r_emit_cur <= 1'b0;
                    end
                end
                default: begin
                    r_emit_held <= r_emit_held;
                end
            endcase

            if (r_state == S_EMIT && !r_emit_held && !r_emit_cur) begin
                if (r_cur_last) begin
                    r_held_vld <= 1'b0;
                end else if (r_cur_use) begin
                    r_held_vld <= 1'b1;
                end
            end

            if (emit_fire) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_fire) begin
            r_cur_idx   <= i_ray_index;
            r_cur_range <= i_range_mm;
            r_cur_ang   <= i_angle;
            r_cur_use   <= in_usable;
            r_cur_last  <= i_scan_end;
            r_cur_beg   <= 1'b0;
            r_x         <= '0;
            r_y         <= '0;
        end

        if (r_state == S_ROM) begin
            r_neg_x <= fold_x.neg;
            r_neg_y <= fold_y.neg;
        end

        if (r_state == S_ROM2) begin
            r_mx <= PROD_W'(r_rom_q);
        end

        if (r_state == S_LOAD) begin
            r_my <= PROD_W'(r_rom_q);
            r_mr <= r_cur_range;
            r_px <= '0;
            r_py <= '0;
        end

        // One multiplier bit per cycle, least significant first.
        if (r_state == S_MUL) begin
            if (r_mr[0]) begin
                r_px <= r_px + r_mx;
                r_py <= r_py + r_my;
            end
            r_mx <= r_mx << 1;
            r_my <= r_my << 1;
            r_mr <= r_mr >> 1;
        end

        if (r_state == S_PROJ) begin
            r_x       <= sx[PROD_W:MAG_W];
            r_y       <= sy[PROD_W:MAG_W];
            r_cur_beg <= 1'b1;
        end

        if (r_state == S_DIFF) begin
            r_qmx <= adx;
            r_qmy <= ady;
            r_qmc <= ABS_W'(r_connect);
            r_qax <= SQ_W'(adx);
            r_qay <= SQ_W'(ady);
            r_qac <= CSQ_W'(r_connect);
            r_sqx <= '0;
            r_sqy <= '0;
            r_sqc <= '0;
        end

        if (r_state == S_SQR) begin
            if (r_qmx[0]) begin
                r_sqx <= r_sqx + r_qax;
            end
            if (r_qmy[0]) begin
                r_sqy <= r_sqy + r_qay;
            end
            if (r_qmc[0]) begin
                r_sqc <= r_sqc + r_qac;
            end
            r_qax <= r_qax << 1;
            r_qay <= r_qay << 1;
            r_qac <= r_qac << 1;
            r_qmx <= r_qmx >> 1;
            r_qmy <= r_qmy >> 1;
            r_qmc <= r_qmc >> 1;
        end

        if (r_state == S_CMP) begin
            r_cur_beg <= new_beg;
        end

        // A usable point that does not end the scan becomes the held one once all beats of this ray are out.
        if (r_state == S_EMIT && !r_emit_held && !r_emit_cur && !r_cur_last && r_cur_use) begin
            r_held_idx <= r_cur_idx;
            r_held_x   <= r_x;
            r_held_y   <= r_y;
            r_held_beg <= r_cur_beg;
        end

        if (emit_fire) begin
            if (r_emit_held) begin
                r_o_idx  <= r_held_idx;
                r_o_use  <= 1'b1;
                r_o_x    <= r_held_x;
                r_o_y    <= r_held_y;
                r_o_beg  <= r_held_beg;
                r_o_end  <= r_held_end;
                r_o_last <= !r_emit_cur;
            end else begin
                r_o_idx  <= r_cur_idx;
                r_o_use  <= r_cur_use;
                r_o_x    <= r_x;
                r_o_y    <= r_y;
                r_o_beg  <= r_cur_beg;
                r_o_end  <= r_cur_use;
                r_o_last <= 1'b1;
            end
        end
    end

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = r_o_valid;
    assign o_out_index     = r_o_idx;
    assign o_usable        = r_o_use;
    assign o_pos_x         = r_o_x;
    assign o_pos_y         = r_o_y;
    assign o_begins_stroke = r_o_beg;
    assign o_ends_stroke   = r_o_end;
    assign o_run_last      = r_o_last;

endmodule

`default_nettype wire

[sim/stroke_beat_checker.sv]
// Checker for the scan stroke segmenter: watches the configuration port and both
// beat channels, predicts every result beat of each accepted ray and compares them.
// Depends on sss_pkg for the field widths, the angle constants and register indexes.

module stroke_beat_checker
    import sss_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,

    input  wire logic                   i_cfg_we,
    input  wire logic                   i_cfg_index,
    input  wire logic [CFG_W-1:0]       i_cfg_data,

    input  wire logic                   i_in_valid,
    input  wire logic                   i_in_stall,
    input  wire logic [IDX_W-1:0]       i_ray_index,
    input  wire logic [RANGE_W-1:0]     i_range_mm,
    input  wire logic [ANG_W-1:0]       i_angle,
    input  wire logic                   i_ray_ok,
    input  wire logic                   i_scan_end,

    input  wire logic                   i_out_valid,
    input  wire logic                   i_out_stall,
    input  wire logic [IDX_W-1:0]       i_out_index,
    input  wire logic                   i_usable,
    input  wire logic [POS_W-1:0]       i_pos_x,
    input  wire logic [POS_W-1:0]       i_pos_y,
    input  wire logic                   i_begins_stroke,
    input  wire logic                   i_ends_stroke,
    input  wire logic                   i_run_last,

    output int                          o_fail_count,
    output int                          o_pending
);

    localparam real TWO_PI = 6.283185307179586476925;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic             usable;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic             begins;
        logic             ends;
        logic             last;
    } stroke_beat_t;

    logic [CFG_W-1:0] horizon_mm;
    logic [CFG_W-1:0] connect_mm;

    bit               held_valid;
    logic [IDX_W-1:0] held_index;
    longint           held_x;
    longint           held_y;
    logic             held_begins;

    stroke_beat_t     beats_due [$];
    int               mismatches    = 0;
    int               beats_waiting = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = beats_waiting;

    // Q15 cosine of an angle in 1/ANGLE_STEPS turns, rounded half away from zero.
    // The angle is folded into the first quarter turn so the rounding is done on a
    // magnitude, which keeps the result odd-symmetric like a quarter-wave table.
    function automatic int q15_cos(input int turn);
        int  a;
        bit  neg;
        real mag;
        a = turn & (ANGLE_STEPS - 1);
        if (a > HALF) begin
            a = ANGLE_STEPS - a;
        end
        neg = (a > QUARTER);
        if (neg) begin
            a = HALF - a;
        end
        mag = 32767.0 * $cos(TWO_PI * a / ANGLE_STEPS);
        return neg ? -$rtoi(mag + 0.5) : $rtoi(mag + 0.5);
    endfunction

    // Rounded projection of a range onto one axis: floor((r*c + 2^14) / 2^15).
    function automatic longint to_mm(input logic [RANGE_W-1:0] range_mm, input int c);
        longint p;
        p = longint'(range_mm) * c + 64'sd16384;
        return p >>> 15;
    endfunction

    function automatic stroke_beat_t make_beat(input logic [IDX_W-1:0] index,
                                               input logic usable,
                                               input longint x, input longint y,
                                               input logic begins, input logic ends);
        stroke_beat_t b;
        b.index  = index;
        b.usable = usable;
        b.pos_x  = POS_W'(x);
        b.pos_y  = POS_W'(y);
        b.begins = begins;
        b.ends   = ends;
        b.last   = 1'b0;
        return b;
    endfunction

    task automatic predict_ray(input logic [IDX_W-1:0] index,
                               input logic [RANGE_W-1:0] range_mm,
                               input logic [ANG_W-1:0] angle,
                               input logic ray_ok, input logic scan_end);
        stroke_beat_t out_beats [2];
        int           n;
        int           i;
        longint       x;
        longint       y;
        longint       dx;
        longint       dy;
        longint       d2;
        logic         begins;
        n = 0;
        if (ray_ok && range_mm <= horizon_mm) begin
            x = to_mm(range_mm, q15_cos(int'(angle)));
            y = to_mm(range_mm, q15_cos(int'(angle) - QUARTER));
            begins = 1'b1;
            if (held_valid) begin
                // The new point decides whether the held point closes its stroke.
                dx = x - held_x;
                dy = y - held_y;
                d2 = dx * dx + dy * dy;
                begins = (longint'(connect_mm) * longint'(connect_mm) > d2) ? 1'b0 : 1'b1;
                out_beats[n] = make_beat(held_index, 1'b1, held_x, held_y, held_begins,
                                         begins);
                n++;
            end
            if (scan_end) begin
                out_beats[n] = make_beat(index, 1'b1, x, y, begins, 1'b1);
                n++;
                held_valid = 1'b0;
            end else begin
                held_valid  = 1'b1;
                held_index  = index;
                held_x      = x;
                held_y      = y;
                held_begins = begins;
            end
        end else begin
            if (scan_end && held_valid) begin
                out_beats[n] = make_beat(held_index, 1'b1, held_x, held_y, held_begins,
                                         1'b1);
                n++;
                held_valid = 1'b0;
            end
            out_beats[n] = make_beat(index, 1'b0, 0, 0, 1'b0, 1'b0);
            n++;
        end
        if (n > 0) begin
            out_beats[n-1].last = 1'b1;
        end
        for (i = 0; i < n; i++) begin
            beats_due.push_back(out_beats[i]);
        end
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        stroke_beat_t want;
        if (!i_rst_n) begin
            horizon_mm  = 16'hFFFF;
            connect_mm  = 16'd100;
            held_valid  = 1'b0;
            held_index  = '0;
            held_x      = 0;
            held_y      = 0;
            held_begins = 1'b0;
            beats_due.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_HORIZON) begin
                    horizon_mm = i_cfg_data;
                end else begin
                    connect_mm = i_cfg_data;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_ray(i_ray_index, i_range_mm, i_angle, i_ray_ok, i_scan_end);
            end
            if (i_out_valid && !i_out_stall) begin
                if (beats_due.size() == 0) begin
                    $error("unexpected result beat for ray %0d", i_out_index);
                    mismatches++;
                end else begin
                    want = beats_due.pop_front();
                    check_field("out_index", want.index, i_out_index);
                    check_field("usable", want.usable, i_usable);
                    check_field("pos_x", $signed(want.pos_x), $signed(i_pos_x));
                    check_field("pos_y", $signed(want.pos_y), $signed(i_pos_y));
                    check_field("begins_stroke", want.begins, i_begins_stroke);
                    check_field("ends_stroke", want.ends, i_ends_stroke);
                    check_field("run_last", want.last, i_run_last);
                end
            end
        end
        beats_waiting = beats_due.size();
    end

endmodule

[sim/scan_stroke_segmenter_tb.sv]
// Top of the scan stroke segmenter testbench: clock, reset, ray and register
// stimulus with random idling, and the verdict. Depends on sss_pkg, the block
// and stroke_beat_checker, which does all prediction and comparison.

module scan_stroke_segmenter_tb;
    import sss_pkg::*;

    localparam int IDLE_LIMIT    = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 60;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;

    logic                cfg_we      = 1'b0;
    logic                cfg_index   = CFG_HORIZON;
    logic [CFG_W-1:0]    cfg_data    = '0;

    logic                ray_valid   = 1'b0;
    logic [IDX_W-1:0]    ray_index   = '0;
    logic [RANGE_W-1:0]  ray_range   = '0;
    logic [ANG_W-1:0]    ray_angle   = '0;
    logic                ray_ok      = 1'b0;
    logic                ray_end     = 1'b0;
    logic                out_stall   = 1'b0;

    wire logic           dut_stall;
    wire logic           dut_valid;
    wire logic [IDX_W-1:0] out_index;
    wire logic           out_usable;
    wire logic signed [POS_W-1:0] out_x;
    wire logic signed [POS_W-1:0] out_y;
    wire logic           out_begins;
    wire logic           out_ends;
    wire logic           out_last;

    int                  fail_count;
    int                  pending;
    int                  idle_cycles = 0;
    int                  rays_sent   = 0;
    bit                  calm        = 1'b0;
    bit                  hold_off_req = 1'b0;

    scan_stroke_segmenter DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_valid         (ray_valid),
        .o_stall         (dut_stall),
        .i_ray_index     (ray_index),
        .i_range_mm      (ray_range),
        .i_angle         (ray_angle),
        .i_ray_ok        (ray_ok),
        .i_scan_end      (ray_end),
        .o_valid         (dut_valid),
        .i_stall         (out_stall),
        .o_out_index     (out_index),
        .o_usable        (out_usable),
        .o_pos_x         (out_x),
        .o_pos_y         (out_y),
        .o_begins_stroke (out_begins),
        .o_ends_stroke   (out_ends),
        .o_run_last      (out_last)
    );

    stroke_beat_checker u_beat_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (ray_valid),
        .i_in_stall      (dut_stall),
        .i_ray_index     (ray_index),
        .i_range_mm      (ray_range),
        .i_angle         (ray_angle),
        .i_ray_ok        (ray_ok),
        .i_scan_end      (ray_end),
        .i_out_valid     (dut_valid),
        .i_out_stall     (out_stall),
        .i_out_index     (out_index),
        .i_usable        (out_usable),
        .i_pos_x         (out_x),
        .i_pos_y         (out_y),
        .i_begins_stroke (out_begins),
        .i_ends_stroke   (out_ends),
        .i_run_last      (out_last),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Offers one ray, possibly after a random gap, and returns at the edge that takes it.
    task automatic send_ray(input logic [IDX_W-1:0] index, input logic [RANGE_W-1:0] range_mm,
                            input logic [ANG_W-1:0] angle, input logic ok, input logic last);
        int gap;
        if (!calm && $urandom_range(99) < 14) begin
            gap = 1;
            while ($urandom_range(99) < 14) begin
                gap++;
            end
            ray_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        ray_valid <= 1'b1;
        ray_index <= index;
        ray_range <= range_mm;
        ray_angle <= angle;
        ray_ok    <= ok;
        ray_end   <= last;
        @(posedge i_clk);
        while (dut_stall) begin
            @(posedge i_clk);
        end
        rays_sent++;
    endtask

    // A first usable ray that does not end its scan gives no beat, so the block may
    // still be busy when nothing is pending; the extra cycles cover its longest ray.
    task automatic settle();
        ray_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_limits(input logic [CFG_W-1:0] horizon, input logic [CFG_W-1:0] connect);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_HORIZON;
        cfg_data  <= horizon;
        @(posedge i_clk);
        cfg_index <= CFG_CONNECT;
        cfg_data  <= connect;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly whole scans with slowly drifting range over neighboring angles, so that
    // strokes form and break; the rest are rays with every field at random.
    task automatic run_scans(input int rays);
        int               stop_at;
        int               len;
        int               k;
        int               step;
        int               range_mm;
        logic [IDX_W-1:0] index;
        logic [ANG_W-1:0] angle;
        stop_at = rays_sent + rays;
        while (rays_sent < stop_at) begin
            if ($urandom_range(99) < 15) begin
                send_ray(IDX_W'($urandom), RANGE_W'($urandom), ANG_W'($urandom),
                         1'($urandom), 1'($urandom));
            end else begin
                len      = $urandom_range(40, 2);
                // A scan is cut short so the ray count stays on target.
                if (len > stop_at - rays_sent) begin
                    len = stop_at - rays_sent;
                end
                index    = IDX_W'($urandom);
                angle    = ANG_W'($urandom);
                step     = $urandom_range(3);
                range_mm = $urandom_range(65535);
                for (k = 0; k < len; k++) begin
                    if ($urandom_range(9) == 0) begin
                        range_mm = $urandom_range(65535);
                    end else begin
                        range_mm = range_mm + $urandom_range(40) - 20;
                        if (range_mm < 0) begin
                            range_mm = 0;
                        end else if (range_mm > 65535) begin
                            range_mm = 65535;
                        end
                    end
                    send_ray(index, RANGE_W'(range_mm), angle, $urandom_range(9) != 0,
                             k == len - 1);
                    index = index + 1'b1;
                    angle = angle + ANG_W'(step);
                end
            end
        end
    endtask

    // Receiver: random stalls, one long hold-off on request, none while calm.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                out_stall <= !calm && ($urandom_range(99) < 14);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((ray_valid && !dut_stall) || (dut_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Register defaults: horizon at its maximum, joining distance of 100 mm.
        send_ray(10'd0, 16'd500, 12'd0, 1'b0, 1'b0);
        send_ray(10'd1, 16'd0, 12'd0, 1'b1, 1'b0);
        send_ray(10'd2, 16'd50, 12'd0, 1'b1, 1'b0);
        // Exactly the joining distance away, which starts a new stroke.
        send_ray(10'd3, 16'd150, 12'd0, 1'b1, 1'b0);
        send_ray(10'd4, 16'hFFFF, 12'd1024, 1'b1, 1'b0);
        // An invalid ray overtakes the held point.
        send_ray(10'd5, 16'd1234, 12'd777, 1'b0, 1'b0);
        send_ray(10'd6, 16'hFFFF, 12'd2048, 1'b1, 1'b0);
        send_ray(10'd7, 16'hFFFF, 12'd3072, 1'b1, 1'b1);
        send_ray(10'd8, 16'hFFFF, 12'd4095, 1'b1, 1'b1);
        send_ray(10'd9, 16'd300, 12'd512, 1'b1, 1'b0);
        send_ray(10'd10, 16'd300, 12'd1536, 1'b0, 1'b1);
        send_ray(10'd1023, 16'd0, 12'd2560, 1'b0, 1'b1);
        settle();

        // A zero joining distance splits even points a millimetre apart.
        set_limits(16'd1000, 16'd0);
        send_ray(10'd0, 16'd1000, 12'd0, 1'b1, 1'b0);
        send_ray(10'd1, 16'd1001, 12'd0, 1'b1, 1'b0);
        send_ray(10'd2, 16'd1000, 12'd0, 1'b1, 1'b0);
        send_ray(10'd3, 16'hFFFF, 12'd100, 1'b1, 1'b1);
        settle();

        set_limits(16'd0, 16'hFFFF);
        send_ray(10'd0, 16'd0, 12'd0, 1'b1, 1'b0);
        send_ray(10'd1, 16'd1, 12'd0, 1'b1, 1'b0);
        send_ray(10'd2, 16'd0, 12'd2048, 1'b1, 1'b1);
        settle();

        set_limits(16'hFFFF, 16'd300);
        run_scans(40);
        hold_off_req = 1'b1;
        run_scans(80);
        settle();

        set_limits(CFG_W'($urandom_range(65535, 5000)), CFG_W'($urandom_range(2000)));
        calm = 1'b1;
        run_scans(70);
        calm = 1'b0;
        run_scans(50);
        settle();

        set_limits(16'hFFFF, 16'hFFFF);
        run_scans(60);
        settle();

        set_limits(CFG_W'($urandom_range(65535)), CFG_W'($urandom_range(65535)));
        run_scans(80);
        settle();

        set_limits(16'd30000, 16'd150);
        run_scans(70);
        settle();

        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
